FILE: design/dcd_pkg.sv
// shared widths, constants, types and tables for the day count difference pipeline
`default_nettype none

package dcd_pkg;

  // port widths
  localparam int JDN_W  = 23;
  localparam int MODE_W = 2;
  localparam int CNT_W  = 23;

  // pipeline stages, numbered from the input side
  localparam int STAGES      = 13;
  localparam int ST_ORDER    = 1;
  localparam int ST_CENT_EST = 2;
  localparam int ST_CENT_REM = 3;
  localparam int ST_CENT     = 4;
  localparam int ST_YR_EST   = 5;
  localparam int ST_YR_REM   = 6;
  localparam int ST_YR       = 7;
  localparam int ST_DOY      = 8;
  localparam int ST_MON_EST  = 9;
  localparam int ST_DATE     = 10;
  localparam int ST_DAYS     = 11;
  localparam int ST_SUM      = 12;
  localparam int ST_OUT      = 13;

  // internal widths
  localparam int A_W       = 24;  // day number plus offset
  localparam int X1_W      = 26;  // four times that
  localparam int CE_PROD_W = 35;  // century estimate product
  localparam int CENT_W    = 8;
  localparam int RC0_W     = 19;  // century remainder before correction
  localparam int A2_W      = 16;  // day within the 400 year cycle
  localparam int AP1_W     = 17;
  localparam int YP_W      = 37;  // year estimate product
  localparam int X2_W      = 28;
  localparam int YR_W      = 7;
  localparam int RY0_W     = 22;
  localparam int QD_W      = 18;
  localparam int A3F_W     = 17;
  localparam int A3_W      = 10;  // day within the shifted year
  localparam int X3_W      = 17;
  localparam int MO_W      = 4;
  localparam int DBM_W     = 9;
  localparam int DAY_W     = 5;
  localparam int MON_W     = 4;
  localparam int YEAR_W    = 15;  // year plus a bias, never negative
  localparam int DM_W      = 5;
  localparam int DY_W      = 16;
  localparam int SUM_W     = 26;

  // calendar split constants
  localparam int JDN_OFFSET = 68569;
  localparam int CENT_DAYS  = 146097;
  localparam int CENT_RECIP = 459;      // floor(2^26 / 146097)
  localparam int YR_SCALE   = 4000;
  localparam int YR_DAYS    = 1461001;
  localparam int YR_RECIP   = 732000;   // 4000 * floor(2^28 / 1461001)
  localparam int QUAD_DAYS  = 1461;
  localparam int DOY_BIAS   = 31;
  localparam int MON_SCALE  = 80;
  localparam int MON_DAYS   = 2447;
  localparam int MONTHS     = 12;
  localparam int MO_WRAP    = 11;
  localparam int MON_SHIFT  = 2;
  localparam int CENTURY    = 100;
  localparam int CENT_BIAS  = 3;        // keeps the biased year a multiple of 400 apart

  // day count constants
  localparam int DAY_30      = 30;
  localparam int DAY_31      = 31;
  localparam int FEB_MONTH   = 2;
  localparam int FEB_LAST    = 28;
  localparam int LEAP_LAST   = 29;
  localparam int DAYS_MONTH  = 30;
  localparam int DAYS_YEAR   = 360;
  localparam int CNT_MAX     = 4194303;
  localparam int CNT_MIN     = -4194304;

  // convention codes
  localparam logic [MODE_W-1:0] MODE_30_360 = 2'd0;
  localparam logic [MODE_W-1:0] MODE_30E    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_30U    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ACTUAL = 2'd3;

  typedef logic [STAGES:1] ld_t;

  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  mon;
    logic [YEAR_W-1:0] year;
    logic              leap;
  } date_t;

  typedef struct packed {
    logic              eq;
    logic              flip;
    logic [MODE_W-1:0] mode;
    logic [JDN_W-1:0]  act;
  } side_t;

  // days before the shifted month: floor(2447 * mo / 80)
  function automatic logic [DBM_W-1:0] days_before(input logic [MO_W-1:0] mo);
    logic [DBM_W-1:0] d;
    case (mo)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd30;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd91;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd152;
      4'd6:    d = 9'd183;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd244;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd305;
      4'd11:   d = 9'd336;
      4'd12:   d = 9'd367;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // last day of february for the split date
  function automatic logic last_of_feb(input date_t dt);
    logic [DAY_W-1:0] last;
    last = dt.leap ? DAY_W'(LEAP_LAST) : DAY_W'(FEB_LAST);
    return (dt.mon == MON_W'(FEB_MONTH)) && (dt.day == last);
  endfunction

endpackage

`default_nettype wire

FILE: design/dcd_split.sv
// pipelined split of a scaled day number into year, month, day and leap flag
`default_nettype none

module dcd_split (
  input  wire logic                     clk,
  input  wire dcd_pkg::ld_t             ld,
  input  wire logic [dcd_pkg::X1_W-1:0] x1,
  output dcd_pkg::date_t                date
);

  // century estimate stage
  logic [dcd_pkg::CE_PROD_W-1:0] ce_prod;
  logic [dcd_pkg::CENT_W-1:0]    qc_nxt, qc_r;
  logic [dcd_pkg::X1_W-1:0]      x1_2r;

  // century remainder stage
  logic [dcd_pkg::X1_W-1:0]   cprod, rc_full;
  logic [dcd_pkg::RC0_W-1:0]  rc0_nxt, rc0_r;
  logic [dcd_pkg::CENT_W-1:0] qc3_r;

  // century correction stage
  logic [dcd_pkg::RC0_W-1:0]  rc;
  logic [dcd_pkg::CENT_W-1:0] cent_nxt, cent4_r;
  logic [dcd_pkg::A2_W-1:0]   a2_nxt, a2_r;

  // year estimate stage
  logic [dcd_pkg::AP1_W-1:0]  ap1;
  logic [dcd_pkg::YP_W-1:0]   x2_full, qy_full;
  logic [dcd_pkg::X2_W-1:0]   x2_nxt, x2_r;
  logic [dcd_pkg::YR_W-1:0]   qy_nxt, qy_r;
  logic [dcd_pkg::A2_W-1:0]   a2_5r;
  logic [dcd_pkg::CENT_W-1:0] cent5_r;

  // year remainder stage
  logic [dcd_pkg::X2_W-1:0]   yprod, ry_full;
  logic [dcd_pkg::RY0_W-1:0]  ry0_nxt, ry0_r;
  logic [dcd_pkg::YR_W-1:0]   qy6_r;
  logic [dcd_pkg::A2_W-1:0]   a2_6r;
  logic [dcd_pkg::CENT_W-1:0] cent6_r;

  // year correction stage
  logic [dcd_pkg::YR_W-1:0]   yr_nxt, yr_r;
  logic [dcd_pkg::A2_W-1:0]   a2_7r;
  logic [dcd_pkg::CENT_W-1:0] cent7_r;

  // day of shifted year stage
  logic [dcd_pkg::QD_W-1:0]   qd;
  logic [dcd_pkg::A3F_W-1:0]  a3_full;
  logic [dcd_pkg::A3_W-1:0]   a3_nxt, a3_r;
  logic [dcd_pkg::YR_W-1:0]   yr8_r;
  logic [dcd_pkg::CENT_W-1:0] cent8_r;

  // month search stage
  logic [dcd_pkg::X3_W-1:0]   x3;
  logic [dcd_pkg::MO_W-1:0]   mo_nxt, mo_r;
  logic [dcd_pkg::A3_W-1:0]   a3_9r;
  logic [dcd_pkg::YR_W-1:0]   yr9_r;
  logic [dcd_pkg::CENT_W-1:0] cent9_r;

  // date assembly stage
  logic [dcd_pkg::A3_W-1:0]   day_full;
  logic                       k;
  logic [dcd_pkg::YR_W-1:0]   r, rr;
  logic [dcd_pkg::CENT_W-1:0] cb, cc;
  logic [dcd_pkg::YEAR_W-1:0] year;
  dcd_pkg::date_t             date_nxt, date_r;

  // century estimate, low by at most one
  always_comb begin
    ce_prod = dcd_pkg::CE_PROD_W'(x1) * dcd_pkg::CE_PROD_W'(dcd_pkg::CENT_RECIP);
    qc_nxt  = ce_prod[dcd_pkg::X1_W +: dcd_pkg::CENT_W];
  end

  always_ff @(posedge clk) begin
    if (ld[dcd_pkg::ST_CENT_EST]) begin
      qc_r  <= qc_nxt;
      x1_2r <= x1;
    end
  end

  // remainder against the estimate
  always_comb begin
    cprod   = dcd_pkg::X1_W'(qc_r) * dcd_pkg::X1_W'(dcd_pkg::CENT_DAYS);
    rc_full = x1_2r - cprod;
    rc0_nxt = rc_full[dcd_pkg::RC0_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ld[dcd_pkg::ST_CENT_REM]) begin
      rc0_r <= rc0_nxt;
      qc3_r <= qc_r;
    end
  end

  // one correction step; the remainder over four is the day in the cycle
  always_comb begin
    if (rc0_r >= dcd_pkg::RC0_W'(dcd_pkg::CENT_DAYS)) begin
      cent_nxt = qc3_r + dcd_pkg::CENT_W'(1);
      rc       = rc0_r - dcd_pkg::RC0_W'(dcd_pkg::CENT_DAYS);
    end else begin
      cent_nxt = qc3_r;
      rc       = rc0_r;
    end
    a2_nxt = rc[dcd_pkg::A2_W+1:2];
  end

  always_ff @(posedge clk) begin
    if (ld[dcd_pkg::ST_CENT]) begin
      cent4_r <= cent_nxt;
      a2_r    <= a2_nxt;
    end
  end

  // year estimate and scaled dividend
  always_comb begin
    ap1     = dcd_pkg::AP1_W'(a2_r) + dcd_pkg::AP1_W'(1);
    x2_full = dcd_pkg::YP_W'(ap1) * dcd_pkg::YP_W'(dcd_pkg::YR_SCALE);
    qy_full = dcd_pkg::YP_W'(ap1) * dcd_pkg::YP_W'(dcd_pkg::YR_RECIP);
    x2_nxt  = x2_full[dcd_pkg::X2_W-1:0];
    qy_nxt  = qy_full[dcd_pkg::X2_W +: dcd_pkg::YR_W];
  end

  always_ff @(posedge clk) begin
    if (ld[dcd_pkg::ST_YR_EST]) begin
      x2_r    <= x2_nxt;
      qy_r    <= qy_nxt;
      a2_5r   <= a2_r;
      cent5_r <= cent4_r;
    end
  end

  // year remainder
  always_comb begin
    yprod   = dcd_pkg::X2_W'(qy_r) * dcd_pkg::X2_W'(dcd_pkg::YR_DAYS);
    ry_full = x2_r - yprod;
    ry0_nxt = ry_full[dcd_pkg::RY0_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ld[dcd_pkg::ST_YR_REM]) begin
      ry0_r   <= ry0_nxt;
      qy6_r   <= qy_r;
      a2_6r   <= a2_5r;
      cent6_r <= cent5_r;
    end
  end

  // year correction
  always_comb begin
    if (ry0_r >= dcd_pkg::RY0_W'(dcd_pkg::YR_DAYS)) begin
      yr_nxt = qy6_r + dcd_pkg::YR_W'(1);
    end else begin
      yr_nxt = qy6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[dcd_pkg::ST_YR]) begin
      yr_r    <= yr_nxt;
      a2_7r   <= a2_6r;
      cent7_r <= cent6_r;
    end
  end

  // day within the march based year, biased by 31
  always_comb begin
    qd      = dcd_pkg::QD_W'(yr_r) * dcd_pkg::QD_W'(dcd_pkg::QUAD_DAYS);
    a3_full = dcd_pkg::A3F_W'(a2_7r) + dcd_pkg::A3F_W'(dcd_pkg::DOY_BIAS)
              - dcd_pkg::A3F_W'(qd[dcd_pkg::QD_W-1:2]);
    a3_nxt  = a3_full[dcd_pkg::A3_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ld[dcd_pkg::ST_DOY]) begin
      a3_r    <= a3_nxt;
      yr8_r   <= yr_r;
      cent8_r <= cent7_r;
    end
  end

  // shifted month: highest month start not above 80 * day
  always_comb begin
    x3     = dcd_pkg::X3_W'(a3_r) * dcd_pkg::X3_W'(dcd_pkg::MON_SCALE);
    mo_nxt = '0;
    for (int m = 1; m <= dcd_pkg::MONTHS; m++) begin
      if (x3 >= dcd_pkg::X3_W'(dcd_pkg::MON_DAYS * m)) begin
        mo_nxt = dcd_pkg::MO_W'(m);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[dcd_pkg::ST_MON_EST]) begin
      mo_r    <= mo_nxt;
      a3_9r   <= a3_r;
      yr9_r   <= yr8_r;
      cent9_r <= cent8_r;
    end
  end

  // day, calendar month, biased year and leap flag
  always_comb begin
    day_full = a3_9r - dcd_pkg::A3_W'(dcd_pkg::days_before(mo_r));
    k        = (mo_r >= dcd_pkg::MO_W'(dcd_pkg::MO_WRAP));
    r        = yr9_r + dcd_pkg::YR_W'(k);
    year     = dcd_pkg::YEAR_W'(cent9_r) * dcd_pkg::YEAR_W'(dcd_pkg::CENTURY)
               + dcd_pkg::YEAR_W'(r);
    cb       = cent9_r + dcd_pkg::CENT_W'(dcd_pkg::CENT_BIAS);
    // year within the century rolls over into the next century
    if (r == dcd_pkg::YR_W'(dcd_pkg::CENTURY)) begin
      rr = '0;
      cc = cb + dcd_pkg::CENT_W'(1);
    end else begin
      rr = r;
      cc = cb;
    end
    date_nxt.day  = day_full[dcd_pkg::DAY_W-1:0];
    date_nxt.mon  = mo_r + dcd_pkg::MO_W'(dcd_pkg::MON_SHIFT)
                    - (k ? dcd_pkg::MO_W'(dcd_pkg::MONTHS) : '0);
    date_nxt.year = year;
    date_nxt.leap = ((rr[1:0] == 2'b00) && (rr != '0))
                    || ((rr == '0) && (cc[1:0] == 2'b00));
  end

  always_ff @(posedge clk) begin
    if (ld[dcd_pkg::ST_DATE]) begin
      date_r <= date_nxt;
    end
  end

  assign date = date_r;

endmodule

`default_nettype wire

FILE: design/day_count_difference.sv
// top level of the day count difference pipeline
//
// Input channel: in_first_day_number, in_second_day_number (Julian day
// numbers) and in_mode (0 = 30/360, 1 = 30E/360, 2 = 30U/360 with the
// end-of-February rule, 3 = actual days), transferred when in_valid is high
// and in_stall is low. Result channel: out_day_count, the signed count from
// the first date to the second, transferred when out_valid is high and
// out_stall is low. Equal dates give zero; counts beyond 23 bits saturate.
//
// Throughput is one pair per cycle unless every stage is full and out_stall
// is high: the 13 stages each hold one item and the logic of each is built
// from constant multiplies, adds, subtracts and compares.
//
// Reset clears every stage's valid bit; no clearing pass is needed.
// When the receiver stalls, the result holds on the output and items behind
// it close up into empty stages; in_stall rises only once every stage is full.
`default_nettype none

module day_count_difference (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output      logic                               in_stall,
  input  wire logic [dcd_pkg::JDN_W-1:0]          in_first_day_number,
  input  wire logic [dcd_pkg::JDN_W-1:0]          in_second_day_number,
  input  wire logic [dcd_pkg::MODE_W-1:0]         in_mode,
  output      logic                               out_valid,
  input  wire logic                               out_stall,
  output      logic signed [dcd_pkg::CNT_W-1:0]   out_day_count
);

  // pipeline control
  logic [dcd_pkg::STAGES+1:1] rdy;
  logic [dcd_pkg::STAGES:1]   v_nxt, v_r;
  dcd_pkg::ld_t               ld;

  // ordering stage
  logic                       flip;
  logic [dcd_pkg::JDN_W-1:0]  lo, hi;
  logic [dcd_pkg::A_W-1:0]    a_lo, a_hi;
  logic [dcd_pkg::X1_W-1:0]   x1_lo_r, x1_hi_r;
  dcd_pkg::side_t             side_nxt;
  dcd_pkg::side_t             side_r [dcd_pkg::ST_ORDER:dcd_pkg::ST_SUM];

  // split dates
  dcd_pkg::date_t             date_a, date_b;

  // day adjustment stage
  logic                             lf_a, lf_b;
  logic [dcd_pkg::DAY_W-1:0]        d1_nxt, d2_nxt, d1_r, d2_r;
  logic signed [dcd_pkg::DM_W-1:0]  dm_nxt, dm_r;
  logic signed [dcd_pkg::DY_W-1:0]  dy_nxt, dy_r;

  // weighted sum stage
  logic signed [dcd_pkg::SUM_W-1:0] dd, mt, yt, sum_nxt, sum_r;

  // sign and saturation stage
  logic signed [dcd_pkg::SUM_W-1:0] cnt, cnt_s;
  logic signed [dcd_pkg::CNT_W-1:0] res_nxt, out_day_count_r;

  // a stage takes new data when empty or when its contents move on
  always_comb begin
    rdy[dcd_pkg::STAGES+1] = !out_stall;
    for (int i = dcd_pkg::STAGES; i >= 1; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign ld       = rdy[dcd_pkg::STAGES:1];
  assign in_stall = !rdy[1];

  // valid bits travel with the data
  always_comb begin
    v_nxt[1] = rdy[1] ? in_valid : v_r[1];
    for (int i = 2; i <= dcd_pkg::STAGES; i++) begin
      v_nxt[i] = rdy[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // order the dates and scale both day numbers for the split
  always_comb begin
    flip          = in_first_day_number > in_second_day_number;
    lo            = flip ? in_second_day_number : in_first_day_number;
    hi            = flip ? in_first_day_number : in_second_day_number;
    a_lo          = dcd_pkg::A_W'(lo) + dcd_pkg::A_W'(dcd_pkg::JDN_OFFSET);
    a_hi          = dcd_pkg::A_W'(hi) + dcd_pkg::A_W'(dcd_pkg::JDN_OFFSET);
    side_nxt.eq   = (in_first_day_number == in_second_day_number);
    side_nxt.flip = flip;
    side_nxt.mode = in_mode;
    side_nxt.act  = hi - lo;
  end

  always_ff @(posedge clk) begin
    if (ld[dcd_pkg::ST_ORDER]) begin
      x1_lo_r <= {a_lo, 2'b00};
      x1_hi_r <= {a_hi, 2'b00};
    end
  end

  // side information follows the item down the pipeline
  always_ff @(posedge clk) begin
    if (ld[dcd_pkg::ST_ORDER]) begin
      side_r[dcd_pkg::ST_ORDER] <= side_nxt;
    end
    for (int i = dcd_pkg::ST_CENT_EST; i <= dcd_pkg::ST_SUM; i++) begin
      if (ld[i]) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // calendar split of the earlier and the later date
  dcd_split u_split_a (
    .clk  (clk),
    .ld   (ld),
    .x1   (x1_lo_r),
    .date (date_a)
  );

  dcd_split u_split_b (
    .clk  (clk),
    .ld   (ld),
    .x1   (x1_hi_r),
    .date (date_b)
  );

  // day adjustment by convention, month and year differences
  always_comb begin
    lf_a   = dcd_pkg::last_of_feb(date_a);
    lf_b   = dcd_pkg::last_of_feb(date_b);
    d1_nxt = date_a.day;
    d2_nxt = date_b.day;
    // end-of-february rule
    if ((side_r[dcd_pkg::ST_DATE].mode == dcd_pkg::MODE_30U) && lf_a) begin
      if (lf_b) begin
        d2_nxt = dcd_pkg::DAY_W'(dcd_pkg::DAY_30);
      end
      d1_nxt = dcd_pkg::DAY_W'(dcd_pkg::DAY_30);
    end
    if (side_r[dcd_pkg::ST_DATE].mode == dcd_pkg::MODE_30E) begin
      if (d1_nxt == dcd_pkg::DAY_W'(dcd_pkg::DAY_31)) begin
        d1_nxt = dcd_pkg::DAY_W'(dcd_pkg::DAY_30);
      end
      if (d2_nxt == dcd_pkg::DAY_W'(dcd_pkg::DAY_31)) begin
        d2_nxt = dcd_pkg::DAY_W'(dcd_pkg::DAY_30);
      end
    end else begin
      if (d1_nxt == dcd_pkg::DAY_W'(dcd_pkg::DAY_31)) begin
        d1_nxt = dcd_pkg::DAY_W'(dcd_pkg::DAY_30);
      end
      if ((d2_nxt == dcd_pkg::DAY_W'(dcd_pkg::DAY_31))
          && (d1_nxt == dcd_pkg::DAY_W'(dcd_pkg::DAY_30))) begin
        d2_nxt = dcd_pkg::DAY_W'(dcd_pkg::DAY_30);
      end
    end
    dm_nxt = $signed({1'b0, date_b.mon}) - $signed({1'b0, date_a.mon});
    dy_nxt = $signed({1'b0, date_b.year}) - $signed({1'b0, date_a.year});
  end

  always_ff @(posedge clk) begin
    if (ld[dcd_pkg::ST_DAYS]) begin
      d1_r <= d1_nxt;
      d2_r <= d2_nxt;
      dm_r <= dm_nxt;
      dy_r <= dy_nxt;
    end
  end

  // 30/360 weighted sum
  always_comb begin
    dd      = $signed(dcd_pkg::SUM_W'(d2_r)) - $signed(dcd_pkg::SUM_W'(d1_r));
    mt      = dcd_pkg::SUM_W'(dm_r) * $signed(dcd_pkg::SUM_W'(dcd_pkg::DAYS_MONTH));
    yt      = dcd_pkg::SUM_W'(dy_r) * $signed(dcd_pkg::SUM_W'(dcd_pkg::DAYS_YEAR));
    sum_nxt = dd + mt + yt;
  end

  always_ff @(posedge clk) begin
    if (ld[dcd_pkg::ST_SUM]) begin
      sum_r <= sum_nxt;
    end
  end

  // pick the convention, apply the sign, saturate to the port
  always_comb begin
    if (side_r[dcd_pkg::ST_SUM].mode == dcd_pkg::MODE_ACTUAL) begin
      cnt = $signed(dcd_pkg::SUM_W'(side_r[dcd_pkg::ST_SUM].act));
    end else begin
      cnt = sum_r;
    end
    cnt_s = side_r[dcd_pkg::ST_SUM].flip ? -cnt : cnt;
    if (side_r[dcd_pkg::ST_SUM].eq) begin
      res_nxt = '0;
    end else if (cnt_s > $signed(dcd_pkg::SUM_W'(dcd_pkg::CNT_MAX))) begin
      res_nxt = dcd_pkg::CNT_W'(dcd_pkg::CNT_MAX);
    end else if (cnt_s < $signed(dcd_pkg::SUM_W'(dcd_pkg::CNT_MIN))) begin
      res_nxt = dcd_pkg::CNT_W'(dcd_pkg::CNT_MIN);
    end else begin
      res_nxt = cnt_s[dcd_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[dcd_pkg::ST_OUT]) begin
      out_day_count_r <= res_nxt;
    end
  end

  assign out_valid     = v_r[dcd_pkg::ST_OUT];
  assign out_day_count = out_day_count_r;

endmodule

`default_nettype wire

FILE: tb/tb_day_count_difference.sv
// self-checking testbench for the day count difference pipeline
`timescale 1ns / 100ps

module tb_day_count_difference;
  import dcd_pkg::*;

  localparam int  CYCLE_LIMIT = 200000;
  localparam int  DRAIN_CYCLES = 4 * STAGES;
  localparam int  RANDOM_PAIRS = 500;
  localparam int  STALL_PHASE = 150;
  localparam int  JDN_LO = 1721426;   // 1 jan of year 1
  localparam int  JDN_HI = 5373484;   // 31 dec of year 9999
  localparam int  JDN_TOP = (1 << JDN_W) - 1;

  typedef struct packed {
    logic [JDN_W-1:0]  first;
    logic [JDN_W-1:0]  second;
    logic [MODE_W-1:0] mode;
  } date_pair_t;

  typedef struct packed {
    longint year;
    longint mon;
    longint day;
  } civil_date_t;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [JDN_W-1:0]         in_first_day_number = '0;
  logic [JDN_W-1:0]         in_second_day_number = '0;
  logic [MODE_W-1:0]        in_mode = MODE_30_360;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [CNT_W-1:0]  out_day_count;

  date_pair_t               pending_pairs[$];
  logic signed [CNT_W-1:0]  day_counts_due[$];
  logic signed [CNT_W-1:0]  due_count;
  date_pair_t               next_pair;
  int                       error_count = 0;
  int                       cycle_count = 0;
  int                       burst_left = 1;
  int                       gap_left = 0;

  day_count_difference u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_first_day_number  (in_first_day_number),
    .in_second_day_number (in_second_day_number),
    .in_mode              (in_mode),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_day_count        (out_day_count)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // gregorian calendar date to julian day number, for building stimulus
  function automatic longint ymd_to_jdn(longint y, longint m, longint d);
    longint a, y2, m2;
    a  = (14 - m) / 12;
    y2 = y + 4800 - a;
    m2 = m + 12 * a - 3;
    return d + (153 * m2 + 2) / 5 + 365 * y2 + y2 / 4 - y2 / 100 + y2 / 400 - 32045;
  endfunction

  // a date within the last four days of a random month, february often
  function automatic longint month_end_jdn(longint y);
    longint m, k, next_first;
    m = ($urandom_range(0, 3) == 0) ? 2 : longint'($urandom_range(1, 12));
    k = longint'($urandom_range(0, 3));
    next_first = (m == 12) ? ymd_to_jdn(y + 1, 1, 1) : ymd_to_jdn(y, m + 1, 1);
    return next_first - 1 - k;
  endfunction

  // fliegel-van flandern split of a day number
  function automatic civil_date_t split_jdn(longint jdn);
    civil_date_t dt;
    longint a, cent, yr, mo, k;
    a    = jdn + 68569;
    cent = (4 * a) / 146097;
    a    = a - (146097 * cent + 3) / 4;
    yr   = (4000 * (a + 1)) / 1461001;
    a    = a - (1461 * yr) / 4 + 31;
    mo   = (80 * a) / 2447;
    dt.day  = a - (2447 * mo) / 80;
    k       = mo / 11;
    dt.mon  = mo + 2 - 12 * k;
    dt.year = 100 * (cent - 49) + yr + k;
    return dt;
  endfunction

  function automatic bit is_feb_end(civil_date_t dt);
    longint y;
    bit     leap;
    y = dt.year + 400000;
    if (y < 0)
      y = 0;
    leap = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    return dt.mon == FEB_MONTH && dt.day == (leap ? LEAP_LAST : FEB_LAST);
  endfunction

  // expected signed count from the first date to the second
  function automatic logic signed [CNT_W-1:0] predict_day_count(
      logic [JDN_W-1:0] first, logic [JDN_W-1:0] second, logic [MODE_W-1:0] mode);
    longint      lo, hi, cnt, d1, d2;
    bit          flip;
    civil_date_t early, late;
    if (first == second) begin
      cnt = 0;
    end else begin
      flip = first > second;
      lo = flip ? second : first;
      hi = flip ? first : second;
      if (mode == MODE_ACTUAL) begin
        cnt = hi - lo;
      end else begin
        early = split_jdn(lo);
        late  = split_jdn(hi);
        d1 = early.day;
        d2 = late.day;
        // end-of-february rule, ahead of the day 31 caps
        if (mode == MODE_30U && is_feb_end(early)) begin
          if (is_feb_end(late))
            d2 = DAY_30;
          d1 = DAY_30;
        end
        if (d1 == DAY_31)
          d1 = DAY_30;
        if (d2 == DAY_31 && (mode == MODE_30E || d1 == DAY_30))
          d2 = DAY_30;
        cnt = (d2 - d1) + DAYS_MONTH * (late.mon - early.mon)
            + DAYS_YEAR * (late.year - early.year);
      end
      if (flip)
        cnt = -cnt;
    end
    if (cnt > CNT_MAX)
      cnt = CNT_MAX;
    if (cnt < CNT_MIN)
      cnt = CNT_MIN;
    return CNT_W'(cnt);
  endfunction

  function automatic void add_pair(longint first, longint second, logic [MODE_W-1:0] mode);
    date_pair_t p;
    p.first  = JDN_W'(first);
    p.second = JDN_W'(second);
    p.mode   = mode;
    pending_pairs.push_back(p);
  endfunction

  // driver: bursts of transfers with random gaps, payload held while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        day_counts_due.push_back(
          predict_day_count(in_first_day_number, in_second_day_number, in_mode));
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (pending_pairs.size() > 0) begin
          next_pair = pending_pairs.pop_front();
          in_first_day_number  <= next_pair.first;
          in_second_day_number <= next_pair.second;
          in_mode              <= next_pair.mode;
          in_valid             <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall: free running, random, then a fixed duty pattern
  always @(posedge clk) begin
    case ((cycle_count / STALL_PHASE) % 3)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 9) < 4);
      default: out_stall <= ((cycle_count % 7) < 3);
    endcase
  end

  // monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (day_counts_due.size() == 0) begin
        $error("day_count: expected none, actual %0d", out_day_count);
        error_count++;
      end else begin
        due_count = day_counts_due.pop_front();
        if (out_day_count !== due_count) begin
          $error("day_count: expected %0d, actual %0d", due_count, out_day_count);
          error_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_day_count_difference: done, errors");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    longint f, s, t, y;
    int     pick;
    logic [MODE_W-1:0] md;

    // equal dates in every convention
    add_pair(2451545, 2451545, MODE_30_360);
    add_pair(2451545, 2451545, MODE_30E);
    add_pair(2451545, 2451545, MODE_30U);
    add_pair(2451545, 2451545, MODE_ACTUAL);
    // field extremes, counts saturating both ways
    add_pair(0, JDN_TOP, MODE_ACTUAL);
    add_pair(JDN_TOP, 0, MODE_ACTUAL);
    add_pair(0, JDN_TOP, MODE_30_360);
    add_pair(JDN_TOP, 0, MODE_30U);
    add_pair(JDN_LO, JDN_HI, MODE_30E);
    add_pair(JDN_HI, JDN_LO, MODE_30U);
    // day 31 caps
    add_pair(ymd_to_jdn(2021, 1, 31), ymd_to_jdn(2021, 3, 31), MODE_30_360);
    add_pair(ymd_to_jdn(2021, 1, 15), ymd_to_jdn(2021, 3, 31), MODE_30_360);
    add_pair(ymd_to_jdn(2021, 1, 15), ymd_to_jdn(2021, 3, 31), MODE_30E);
    add_pair(ymd_to_jdn(2021, 1, 30), ymd_to_jdn(2021, 3, 31), MODE_30U);
    // end of february, leap and common years, century years
    add_pair(ymd_to_jdn(2021, 2, 28), ymd_to_jdn(2021, 3, 31), MODE_30U);
    add_pair(ymd_to_jdn(2021, 2, 28), ymd_to_jdn(2021, 3, 31), MODE_30_360);
    add_pair(ymd_to_jdn(2020, 2, 29), ymd_to_jdn(2021, 2, 28), MODE_30U);
    add_pair(ymd_to_jdn(2021, 2, 28), ymd_to_jdn(2020, 2, 29), MODE_30U);
    add_pair(ymd_to_jdn(2020, 2, 28), ymd_to_jdn(2020, 3, 31), MODE_30U);
    add_pair(ymd_to_jdn(2100, 2, 28), ymd_to_jdn(2100, 3, 31), MODE_30U);
    add_pair(ymd_to_jdn(2000, 2, 29), ymd_to_jdn(2001, 2, 28), MODE_30U);
    // day numbers before year 1
    add_pair(0, 1, MODE_30U);
    add_pair(1000, 400000, MODE_30_360);

    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      pick = int'($urandom_range(0, 99));
      md   = MODE_W'($urandom_range(0, 3));
      if (pick < 30) begin
        f = longint'($urandom_range(JDN_LO, JDN_HI));
        s = longint'($urandom_range(JDN_LO, JDN_HI));
      end else if (pick < 55) begin
        f = longint'($urandom_range(JDN_LO + 1000, JDN_HI - 1000));
        s = f + longint'($urandom_range(0, 1600)) - 800;
      end else if (pick < 85) begin
        y = longint'($urandom_range(1, 9997));
        f = month_end_jdn(y);
        s = month_end_jdn(y + longint'($urandom_range(0, 2)));
      end else begin
        f = longint'($urandom_range(0, JDN_TOP));
        s = ($urandom_range(0, 1) == 0) ? longint'($urandom_range(0, JDN_TOP))
                                        : f ^ longint'($urandom_range(0, 4095));
      end
      if ($urandom_range(0, 1) == 0) begin
        t = f;
        f = s;
        s = t;
      end
      if ($urandom_range(0, 24) == 0)
        s = f;
      add_pair(f, s, md);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // all transfers in, then all results out
    while (pending_pairs.size() != 0 || in_valid)
      @(posedge clk);
    while (day_counts_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("tb_day_count_difference: done, clean");
    else
      $display("tb_day_count_difference: done, errors");
    $finish;
  end

endmodule
